### sv/dcps_pkg.sv
// Shared types and fixed widths for the spring constraint projection pipeline.
package dcps_pkg;

    localparam int VIDX_W = 12;   // vertex index
    localparam int POS_W  = 32;   // signed Q position / addition
    localparam int LEN_W  = 31;   // unsigned Q length, stiffness
    localparam int DIFF_W = 33;   // magnitude of a coordinate difference
    localparam int SQ_W   = 66;   // one squared difference
    localparam int SUM_W  = 68;   // sum of three squares
    localparam int ROOT_W = 34;   // integer square root of the sum
    localparam int REM_W  = 36;   // square root partial remainder
    localparam int NUM_W  = 64;   // |r| * rest_length (+ rounding bias)
    localparam int QUO_W  = 32;   // projected magnitude
    localparam int TERM_W = 34;   // d + q, q - d
    localparam int PROD_W = 66;   // stiffness times term
    localparam int PIN_W  = 3 * POS_W + 1;  // pin flag over three pin coordinates

    localparam int SQRT_STEPS = ROOT_W;
    localparam int DIV_STEPS  = QUO_W;

    localparam logic CMD_EDGE = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    // Payload that travels along with every edge through the pipeline
    typedef struct packed {
        logic [VIDX_W-1:0]            va;
        logic [VIDX_W-1:0]            vb;
        logic [2:0]                   neg;
        logic [2:0][DIFF_W-1:0]       mag;
        logic [LEN_W-1:0]             k;
        logic [LEN_W-1:0]             rest;
        logic                         a_pin;
        logic                         b_pin;
        logic [2:0][POS_W-1:0]        qa;
        logic [2:0][POS_W-1:0]        qb;
        logic [ROOT_W-1:0]            len;
        logic                         len_short;
    } t_item;

endpackage

### sv/distance_constraint_project_scatter.sv
// Spring edge projection and right-hand-side scatter, fully pipelined.
//
// Input channel (i_valid / o_stall) takes one item per cycle while o_stall is low.
// A command of CMD_LOAD writes the pin flag and pin position of i_vertex_a (if
// below MAX_VERTICES) and yields no result; CMD_EDGE yields exactly one result
// on the output channel (o_valid / i_stall), in input order.
// o_valid rises after the transfer edge, through 74 register stages:
// a difference stage, squares, sum, 34 square-root stages (one root bit each),
// numerator multiply and rounding bias, 32 divider stages (one quotient bit
// each), terms, stiffness multiply and the saturating output register.
// Throughput is one item per cycle unless held. The pipeline advances whenever the
// output register is free or being taken, or its last stage is empty, so
// items keep entering while a finished result waits under i_stall until the
// next result reaches the last stage; from then on the input is held.
// After reset the pin table is cleared entry by entry, during which
// o_stall stays high; min_length resets to 1 and may be written at any idle
// time through i_cfg_wr_en / i_cfg_wr_data.
module distance_constraint_project_scatter
    import dcps_pkg::*;
#(
    parameter int MAX_VERTICES = 4096,
    parameter int FRAC_BITS    = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_wr_en,
    input  logic [LEN_W-1:0]         i_cfg_wr_data,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic                     i_command,
    input  logic [VIDX_W-1:0]        i_vertex_a,
    input  logic [VIDX_W-1:0]        i_vertex_b,
    input  logic signed [POS_W-1:0]  i_pos_a_x,
    input  logic signed [POS_W-1:0]  i_pos_a_y,
    input  logic signed [POS_W-1:0]  i_pos_a_z,
    input  logic signed [POS_W-1:0]  i_pos_b_x,
    input  logic signed [POS_W-1:0]  i_pos_b_y,
    input  logic signed [POS_W-1:0]  i_pos_b_z,
    input  logic [LEN_W-1:0]         i_rest_length,
    input  logic [LEN_W-1:0]         i_stiffness,
    input  logic                     i_pin_flag,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [VIDX_W-1:0]        o_out_vertex_a,
    output logic [VIDX_W-1:0]        o_out_vertex_b,
    output logic signed [POS_W-1:0]  o_add_a_x,
    output logic signed [POS_W-1:0]  o_add_a_y,
    output logic signed [POS_W-1:0]  o_add_a_z,
    output logic signed [POS_W-1:0]  o_add_b_x,
    output logic signed [POS_W-1:0]  o_add_b_y,
    output logic signed [POS_W-1:0]  o_add_b_z,
    output logic                     o_write_a,
    output logic                     o_write_b
);

    localparam int AW     = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int S_DIFF = 0;
    localparam int S_SQR  = 1;
    localparam int S_SUM  = 2;
    localparam int S_RT0  = 3;
    localparam int S_NUM  = S_RT0 + SQRT_STEPS;
    localparam int S_BIAS = S_NUM + 1;
    localparam int S_DV0  = S_BIAS + 1;
    localparam int S_TERM = S_DV0 + DIV_STEPS;
    localparam int S_MUL  = S_TERM + 1;
    localparam int NSTG   = S_MUL + 1;

    // configuration and control
    logic [LEN_W-1:0]  r_min_length;
    logic              r_clr_busy;
    logic [AW-1:0]     r_clr_cnt;
    logic              w_adv;
    logic              w_acc;
    logic              w_load;
    logic              w_out_ld;
    logic              w_rng_a;
    logic              w_rng_b;
    logic [AW-1:0]     w_addr_a;
    logic [AW-1:0]     w_addr_b;

    // pin table
    logic [PIN_W-1:0]  r_mem [MAX_VERTICES];
    logic [PIN_W-1:0]  r_rd_a;
    logic [PIN_W-1:0]  r_rd_b;
    logic              r_rng_a;
    logic              r_rng_b;

    // pipeline
    logic [NSTG-1:0]   r_vld;
    t_item             r_item [NSTG];
    t_item             n_item [NSTG];
    logic [SQ_W-1:0]   r_sq [3];
    logic [SUM_W-1:0]  r_sum;
    logic [REM_W-1:0]  r_rt_rem  [SQRT_STEPS];
    logic [ROOT_W-1:0] r_rt_root [SQRT_STEPS];
    logic [SUM_W-1:0]  r_rt_rad  [SQRT_STEPS];
    logic [REM_W-1:0]  n_rt_rem  [SQRT_STEPS];
    logic [ROOT_W-1:0] n_rt_root [SQRT_STEPS];
    logic [SUM_W-1:0]  n_rt_rad  [SQRT_STEPS];
    logic [NUM_W-1:0]  r_num  [3];
    logic [NUM_W-1:0]  r_nbias [3];
    logic [ROOT_W-1:0] r_dv_rem [DIV_STEPS][3];
    logic [QUO_W-1:0]  r_dv_nlo [DIV_STEPS][3];
    logic [QUO_W-1:0]  r_dv_q   [DIV_STEPS][3];
    logic [ROOT_W-1:0] n_dv_rem [DIV_STEPS][3];
    logic [QUO_W-1:0]  n_dv_nlo [DIV_STEPS][3];
    logic [QUO_W-1:0]  n_dv_q   [DIV_STEPS][3];
    logic signed [TERM_W-1:0] r_ta [3];
    logic signed [TERM_W-1:0] r_tb [3];
    logic signed [TERM_W-1:0] n_ta [3];
    logic signed [TERM_W-1:0] n_tb [3];
    logic signed [PROD_W-1:0] r_prod [6];
    logic signed [POS_W-1:0]  n_add [6];

    // output register
    logic              r_out_valid;
    logic [VIDX_W-1:0] r_out_va;
    logic [VIDX_W-1:0] r_out_vb;
    logic [POS_W-1:0]  r_out_add [6];
    logic              r_out_wa;
    logic              r_out_wb;

    // handshake: advance unless a valid last stage sits behind a stalled result
    always_comb begin
        w_adv    = !r_out_valid || !i_stall || !r_vld[S_MUL];
        w_out_ld = !r_out_valid || !i_stall;
        o_stall  = r_clr_busy || !w_adv;
        w_acc    = i_valid && !o_stall;
        w_rng_a  = ({20'd0, i_vertex_a} < MAX_VERTICES);
        w_rng_b  = ({20'd0, i_vertex_b} < MAX_VERTICES);
        w_addr_a = AW'(i_vertex_a);
        w_addr_b = AW'(i_vertex_b);
        w_load   = w_acc && (i_command == CMD_LOAD) && w_rng_a;
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_length <= LEN_W'(1);
        end else if (i_cfg_wr_en) begin
            r_min_length <= i_cfg_wr_data;
        end
    end

    // clearing pass over the pin table after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_cnt  <= '0;
        end else if (r_clr_busy) begin
            r_clr_cnt <= r_clr_cnt + AW'(1);
            if (r_clr_cnt == AW'(MAX_VERTICES - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // pin table: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_cnt] <= '0;
        end else if (w_load) begin
            r_mem[w_addr_a] <= {i_pin_flag, i_pos_a_z, i_pos_a_y, i_pos_a_x};
        end
        if (w_adv) begin
            r_rd_a  <= r_mem[w_addr_a];
            r_rd_b  <= r_mem[w_addr_b];
            r_rng_a <= w_rng_a;
            r_rng_b <= w_rng_b;
        end
    end

    // item payload: entry, pin join and length capture
    always_comb begin
        logic signed [DIFF_W-1:0] d;
        logic signed [POS_W-1:0]  pa [3];
        logic signed [POS_W-1:0]  pb [3];
        pa[0] = i_pos_a_x;
        pa[1] = i_pos_a_y;
        pa[2] = i_pos_a_z;
        pb[0] = i_pos_b_x;
        pb[1] = i_pos_b_y;
        pb[2] = i_pos_b_z;
        n_item[S_DIFF] = '0;
        n_item[S_DIFF].va   = i_vertex_a;
        n_item[S_DIFF].vb   = i_vertex_b;
        n_item[S_DIFF].k    = i_stiffness;
        n_item[S_DIFF].rest = i_rest_length;
        for (int i = 0; i < 3; i++) begin
            d = DIFF_W'(pa[i]) - DIFF_W'(pb[i]);
            n_item[S_DIFF].neg[i] = d[DIFF_W-1];
            n_item[S_DIFF].mag[i] = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
        end
        for (int s = 1; s < NSTG; s++) begin
            n_item[s] = r_item[s-1];
        end
        n_item[S_SQR].a_pin = r_rng_a && r_rd_a[PIN_W-1];
        n_item[S_SQR].b_pin = r_rng_b && r_rd_b[PIN_W-1];
        for (int i = 0; i < 3; i++) begin
            n_item[S_SQR].qa[i] = n_item[S_SQR].a_pin ? r_rd_a[i*POS_W +: POS_W] : '0;
            n_item[S_SQR].qb[i] = n_item[S_SQR].b_pin ? r_rd_b[i*POS_W +: POS_W] : '0;
        end
        n_item[S_NUM].len       = r_rt_root[SQRT_STEPS-1];
        n_item[S_NUM].len_short =
            (r_rt_root[SQRT_STEPS-1] <= ROOT_W'(r_min_length));
    end

    // square root: one result bit per stage
    for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_rt
        logic [REM_W-1:0]  rem_p;
        logic [ROOT_W-1:0] root_p;
        logic [SUM_W-1:0]  rad_p;
        logic [REM_W+1:0]  rem2;
        logic [REM_W+1:0]  trial;
        if (j == 0) begin : g_first
            assign rem_p  = '0;
            assign root_p = '0;
            assign rad_p  = r_sum;
        end else begin : g_next
            assign rem_p  = r_rt_rem[j-1];
            assign root_p = r_rt_root[j-1];
            assign rad_p  = r_rt_rad[j-1];
        end
        always_comb begin
            rem2  = {rem_p, rad_p[SUM_W-1 -: 2]};
            trial = {2'b00, root_p, 2'b01};
            n_rt_rad[j] = {rad_p[SUM_W-3:0], 2'b00};
            if (rem2 >= trial) begin
                n_rt_rem[j]  = REM_W'(rem2 - trial);
                n_rt_root[j] = {root_p[ROOT_W-2:0], 1'b1};
            end else begin
                n_rt_rem[j]  = rem2[REM_W-1:0];
                n_rt_root[j] = {root_p[ROOT_W-2:0], 1'b0};
            end
        end
    end

    // divider: one quotient bit per stage and lane
    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_dv
        for (genvar i = 0; i < 3; i++) begin : g_lane
            logic [ROOT_W-1:0] rem_p;
            logic [QUO_W-1:0]  nlo_p;
            logic [QUO_W-1:0]  q_p;
            logic [ROOT_W:0]   rem2;
            logic [ROOT_W:0]   dvs;
            if (j == 0) begin : g_first
                assign rem_p = ROOT_W'(r_nbias[i][NUM_W-1:QUO_W]);
                assign nlo_p = r_nbias[i][QUO_W-1:0];
                assign q_p   = '0;
            end else begin : g_next
                assign rem_p = r_dv_rem[j-1][i];
                assign nlo_p = r_dv_nlo[j-1][i];
                assign q_p   = r_dv_q[j-1][i];
            end
            always_comb begin
                rem2 = {rem_p, nlo_p[QUO_W-1]};
                dvs  = {1'b0, r_item[S_DV0+j-1].len};
                n_dv_nlo[j][i] = {nlo_p[QUO_W-2:0], 1'b0};
                if (rem2 >= dvs) begin
                    n_dv_rem[j][i] = ROOT_W'(rem2 - dvs);
                    n_dv_q[j][i]   = {q_p[QUO_W-2:0], 1'b1};
                end else begin
                    n_dv_rem[j][i] = rem2[ROOT_W-1:0];
                    n_dv_q[j][i]   = {q_p[QUO_W-2:0], 1'b0};
                end
            end
        end
    end

    // signed projection and pin terms
    always_comb begin
        logic signed [DIFF_W-1:0] d;
        t_item it;
        it = r_item[S_TERM-1];
        for (int i = 0; i < 3; i++) begin
            d = $signed({1'b0, r_dv_q[DIV_STEPS-1][i]});
            if (it.len_short) begin
                d = '0;
            end else if (it.neg[i]) begin
                d = -d;
            end
            n_ta[i] = TERM_W'(d) + TERM_W'($signed(it.qb[i]));
            n_tb[i] = TERM_W'($signed(it.qa[i])) - TERM_W'(d);
        end
    end

    // datapath registers, all advancing together
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int s = 0; s < NSTG; s++) begin
                r_item[s] <= n_item[s];
            end
            for (int i = 0; i < 3; i++) begin
                r_sq[i]    <= SQ_W'(r_item[S_DIFF].mag[i]) * SQ_W'(r_item[S_DIFF].mag[i]);
                r_num[i]   <= NUM_W'(r_item[S_NUM-1].mag[i]) * NUM_W'(r_item[S_NUM-1].rest);
                r_nbias[i] <= r_num[i] + NUM_W'(r_item[S_BIAS-1].len >> 1);
                r_ta[i]    <= n_ta[i];
                r_tb[i]    <= n_tb[i];
                r_prod[i]   <= PROD_W'(r_ta[i]) * PROD_W'($signed({1'b0, r_item[S_MUL-1].k}));
                r_prod[i+3] <= PROD_W'(r_tb[i]) * PROD_W'($signed({1'b0, r_item[S_MUL-1].k}));
            end
            r_sum <= SUM_W'(r_sq[0]) + SUM_W'(r_sq[1]) + SUM_W'(r_sq[2]);
            for (int j = 0; j < SQRT_STEPS; j++) begin
                r_rt_rem[j]  <= n_rt_rem[j];
                r_rt_root[j] <= n_rt_root[j];
                r_rt_rad[j]  <= n_rt_rad[j];
            end
            for (int j = 0; j < DIV_STEPS; j++) begin
                for (int i = 0; i < 3; i++) begin
                    r_dv_rem[j][i] <= n_dv_rem[j][i];
                    r_dv_nlo[j][i] <= n_dv_nlo[j][i];
                    r_dv_q[j][i]   <= n_dv_q[j][i];
                end
            end
        end
    end

    // valid bits travel with the data; loads do not enter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[NSTG-2:0], w_acc && (i_command == CMD_EDGE)};
        end
    end

    // round half away from zero, drop fraction bits, saturate
    always_comb begin
        logic [PROD_W-1:0] mag;
        logic [PROD_W-1:0] m;
        for (int i = 0; i < 6; i++) begin
            mag = r_prod[i][PROD_W-1] ? PROD_W'(-r_prod[i]) : PROD_W'(r_prod[i]);
            m   = (mag + (PROD_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
            if (r_prod[i][PROD_W-1]) begin
                n_add[i] = (m > PROD_W'(33'h080000000)) ? POS_W'(32'sh80000000)
                                                         : POS_W'(-m);
            end else begin
                n_add[i] = (m > PROD_W'(32'h7FFFFFFF)) ? POS_W'(32'sh7FFFFFFF)
                                                        : POS_W'(m);
            end
        end
    end

    // output register: hold under stall, zero a pinned end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_ld) begin
            r_out_valid <= r_vld[S_MUL];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_ld) begin
            r_out_va <= r_item[S_MUL].va;
            r_out_vb <= r_item[S_MUL].vb;
            r_out_wa <= !r_item[S_MUL].a_pin;
            r_out_wb <= !r_item[S_MUL].b_pin;
            for (int i = 0; i < 3; i++) begin
                r_out_add[i]   <= r_item[S_MUL].a_pin ? '0 : n_add[i];
                r_out_add[i+3] <= r_item[S_MUL].b_pin ? '0 : n_add[i+3];
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_out_vertex_a = r_out_va;
    assign o_out_vertex_b = r_out_vb;
    assign o_add_a_x      = r_out_add[0];
    assign o_add_a_y      = r_out_add[1];
    assign o_add_a_z      = r_out_add[2];
    assign o_add_b_x      = r_out_add[3];
    assign o_add_b_y      = r_out_add[4];
    assign o_add_b_z      = r_out_add[5];
    assign o_write_a      = r_out_wa;
    assign o_write_b      = r_out_wb;

`ifndef SYNTHESIS
    // no transfer while the pin table is being cleared
    a_clr_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> o_stall)
        else $error("input taken during pin table clear");

    // an empty pipe tail never holds the input
    a_tail_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_clr_busy && !r_vld[S_MUL]) |-> !o_stall)
        else $error("input stalled with empty pipeline tail");

    // a held pipe keeps every valid bit
    a_pipe_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_adv) |=> $stable(r_vld))
        else $error("pipeline moved while held");

    // a new result only comes from a valid last stage
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_vld[S_MUL]))
        else $error("result without a valid edge");
`endif

endmodule

### tb/sv/distance_constraint_project_scatter_tb.sv
// Testbench for the spring constraint projection and scatter block.
`timescale 1ns / 100ps

module distance_constraint_project_scatter_tb;
    import dcps_pkg::*;

    localparam int NVERT    = 4096;
    localparam int FRAC     = 16;
    localparam int PIPE_LAT = 74;
    localparam int CLK_HALF = 6;

    typedef struct {
        logic                     cmd;
        logic [VIDX_W-1:0]        va;
        logic [VIDX_W-1:0]        vb;
        logic signed [POS_W-1:0]  pa [3];
        logic signed [POS_W-1:0]  pb [3];
        logic [LEN_W-1:0]         rest;
        logic [LEN_W-1:0]         k;
        logic                     pin;
    } edge_req_t;

    typedef struct {
        logic [VIDX_W-1:0]        va;
        logic [VIDX_W-1:0]        vb;
        logic signed [POS_W-1:0]  add_a [3];
        logic signed [POS_W-1:0]  add_b [3];
        logic                     wr_a;
        logic                     wr_b;
    } rhs_add_t;

    logic i_clk, i_rst_n;
    logic i_cfg_wr_en;
    logic [LEN_W-1:0] i_cfg_wr_data;
    logic i_valid, o_stall, i_stall, o_valid;
    logic i_command, i_pin_flag;
    logic [VIDX_W-1:0] i_vertex_a, i_vertex_b, o_out_vertex_a, o_out_vertex_b;
    logic signed [POS_W-1:0] i_pos_a_x, i_pos_a_y, i_pos_a_z;
    logic signed [POS_W-1:0] i_pos_b_x, i_pos_b_y, i_pos_b_z;
    logic [LEN_W-1:0] i_rest_length, i_stiffness;
    logic signed [POS_W-1:0] o_add_a_x, o_add_a_y, o_add_a_z;
    logic signed [POS_W-1:0] o_add_b_x, o_add_b_y, o_add_b_z;
    logic o_write_a, o_write_b;

    distance_constraint_project_scatter uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_wr_data(i_cfg_wr_data),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_command(i_command), .i_vertex_a(i_vertex_a), .i_vertex_b(i_vertex_b),
        .i_pos_a_x(i_pos_a_x), .i_pos_a_y(i_pos_a_y), .i_pos_a_z(i_pos_a_z),
        .i_pos_b_x(i_pos_b_x), .i_pos_b_y(i_pos_b_y), .i_pos_b_z(i_pos_b_z),
        .i_rest_length(i_rest_length), .i_stiffness(i_stiffness),
        .i_pin_flag(i_pin_flag),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_out_vertex_a(o_out_vertex_a), .o_out_vertex_b(o_out_vertex_b),
        .o_add_a_x(o_add_a_x), .o_add_a_y(o_add_a_y), .o_add_a_z(o_add_a_z),
        .o_add_b_x(o_add_b_x), .o_add_b_y(o_add_b_y), .o_add_b_z(o_add_b_z),
        .o_write_a(o_write_a), .o_write_b(o_write_b)
    );

    // Shadow state of the block
    logic [LEN_W-1:0]        min_len;
    logic                    pin_flags [NVERT];
    logic signed [POS_W-1:0] pin_pos [NVERT][3];

    rhs_add_t pending_rhs [$];
    int  err_cnt;
    bit  no_idle;
    int  stall_left;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #20ms;
        $display("*** FAILED ***");
        $finish;
    end

    // Round half away from zero, drop the fraction and saturate
    function automatic logic [POS_W-1:0] round_sat(input longint p);
        longint unsigned m;
        begin
            m = (p < 0) ? longint'(-p) : longint'(p);
            m = (m + (64'd1 << (FRAC - 1))) >> FRAC;
            if (p < 0) begin
                if (m > 64'h8000_0000) m = 64'h8000_0000;
                return POS_W'(-m);
            end
            if (m > 64'h7FFF_FFFF) m = 64'h7FFF_FFFF;
            return POS_W'(m);
        end
    endfunction

    // Update the shadow tables or compute the additions of one edge
    function automatic bit project_edge(input edge_req_t it, output rhs_add_t res);
        longint r [3];
        longint d [3];
        longint qa, qb;
        logic [DIFF_W-1:0] mg [3];
        logic [SUM_W-1:0] sum;
        logic [ROOT_W-1:0] len, cand;
        logic [63:0] num, quo;
        bit a_pin, b_pin;
        begin
            if (it.cmd == CMD_LOAD) begin
                pin_flags[it.va] = it.pin;
                for (int i = 0; i < 3; i++) pin_pos[it.va][i] = it.pa[i];
                return 1'b0;
            end
            sum = '0;
            for (int i = 0; i < 3; i++) begin
                r[i] = longint'(it.pa[i]) - longint'(it.pb[i]);
                mg[i] = (r[i] < 0) ? DIFF_W'(-r[i]) : DIFF_W'(r[i]);
                sum = sum + SUM_W'(mg[i]) * SUM_W'(mg[i]);
            end
            len = '0;
            for (int b = ROOT_W - 1; b >= 0; b--) begin
                cand = len | (ROOT_W'(1) << b);
                if (SUM_W'(cand) * SUM_W'(cand) <= sum) len = cand;
            end
            for (int i = 0; i < 3; i++) begin
                if (len <= ROOT_W'(min_len)) begin
                    d[i] = 0;
                end else begin
                    num = 64'(mg[i]) * 64'(it.rest) + 64'(len >> 1);
                    quo = num / 64'(len);
                    d[i] = (r[i] < 0) ? -longint'(quo) : longint'(quo);
                end
            end
            a_pin = pin_flags[it.va];
            b_pin = pin_flags[it.vb];
            res.va = it.va;
            res.vb = it.vb;
            for (int i = 0; i < 3; i++) begin
                qa = a_pin ? longint'(pin_pos[it.va][i]) : 0;
                qb = b_pin ? longint'(pin_pos[it.vb][i]) : 0;
                res.add_a[i] = '0;
                res.add_b[i] = '0;
                if (!(a_pin && b_pin)) begin
                    if (!a_pin) res.add_a[i] = round_sat(longint'(it.k) * (d[i] + qb));
                    if (!b_pin) res.add_b[i] = round_sat(longint'(it.k) * (qa - d[i]));
                end
            end
            res.wr_a = ~a_pin;
            res.wr_b = ~b_pin;
            return 1'b1;
        end
    endfunction

    // Drive one item after a random idle gap (possibly none) and hold it until the transfer
    task automatic send_item(input edge_req_t it);
        rhs_add_t res;
        int gap;
        begin
            gap = no_idle ? 0 : $urandom_range(0, 9);
            if (gap > 0) begin
                i_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_valid       = 1'b1;
            i_command     = it.cmd;
            i_vertex_a    = it.va;
            i_vertex_b    = it.vb;
            i_pos_a_x     = it.pa[0];
            i_pos_a_y     = it.pa[1];
            i_pos_a_z     = it.pa[2];
            i_pos_b_x     = it.pb[0];
            i_pos_b_y     = it.pb[1];
            i_pos_b_z     = it.pb[2];
            i_rest_length = it.rest;
            i_stiffness   = it.k;
            i_pin_flag    = it.pin;
            do @(posedge i_clk); while (o_stall);
            if (project_edge(it, res)) pending_rhs.push_back(res);
            @(negedge i_clk);
        end
    endtask

    // Drain all results, let trailing loads retire, then write min_length
    task automatic write_min_length(input logic [LEN_W-1:0] val);
        begin
            i_valid = 1'b0;
            while (pending_rhs.size() != 0) @(negedge i_clk);
            repeat (PIPE_LAT + 8) @(negedge i_clk);
            i_cfg_wr_en   = 1'b1;
            i_cfg_wr_data = val;
            @(negedge i_clk);
            i_cfg_wr_en = 1'b0;
            min_len = val;
        end
    endtask

    function automatic edge_req_t make_edge(input logic [VIDX_W-1:0] va, vb,
                                            input longint ax, ay, az, bx, by, bz,
                                            input logic [LEN_W-1:0] rest, k);
        edge_req_t it;
        begin
            it.cmd = CMD_EDGE; it.va = va; it.vb = vb; it.pin = 1'b0;
            it.pa[0] = POS_W'(ax); it.pa[1] = POS_W'(ay); it.pa[2] = POS_W'(az);
            it.pb[0] = POS_W'(bx); it.pb[1] = POS_W'(by); it.pb[2] = POS_W'(bz);
            it.rest = rest; it.k = k;
            return it;
        end
    endfunction

    function automatic edge_req_t make_load(input logic [VIDX_W-1:0] v, input logic pin,
                                            input longint x, y, z);
        edge_req_t it;
        begin
            it = make_edge(v, VIDX_W'($urandom), x, y, z, longint'($urandom),
                           longint'($urandom), longint'($urandom),
                           LEN_W'($urandom), LEN_W'($urandom));
            it.cmd = CMD_LOAD;
            it.pin = pin;
            return it;
        end
    endfunction

    // Random edge or load with random content
    function automatic edge_req_t rand_item();
        edge_req_t it;
        int shift;
        begin
            it.cmd  = ($urandom_range(0, 9) == 0) ? CMD_LOAD : CMD_EDGE;
            it.pin  = $urandom_range(0, 2) != 0;
            it.va   = ($urandom_range(0, 3) == 0) ? VIDX_W'($urandom)
                                                  : VIDX_W'($urandom_range(0, 31));
            it.vb   = ($urandom_range(0, 3) == 0) ? VIDX_W'($urandom)
                                                  : VIDX_W'($urandom_range(0, 31));
            shift   = $urandom_range(0, 31);
            for (int i = 0; i < 3; i++) begin
                it.pa[i] = $signed($urandom) >>> shift;
                it.pb[i] = $signed($urandom) >>> shift;
            end
            it.rest = ($urandom_range(0, 3) == 0) ? LEN_W'($urandom)
                                                  : LEN_W'($urandom >> $urandom_range(1, 31));
            it.k    = ($urandom_range(0, 3) == 0) ? LEN_W'($urandom)
                                                  : LEN_W'($urandom >> $urandom_range(1, 31));
            return it;
        end
    endfunction

    // Receiver: stall for a random count before each transfer
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_stall    <= 1'b1;
            stall_left <= stall_left - 1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Compare each transfer with the oldest pending result
    always @(posedge i_clk) begin
        rhs_add_t ex;
        if (i_rst_n && o_valid && !i_stall) begin
            stall_left <= no_idle ? 0 : $urandom_range(0, 9);
            if (pending_rhs.size() == 0) begin
                $error("unexpected result vertex_a=%0d", o_out_vertex_a);
                err_cnt++;
            end else begin
                ex = pending_rhs.pop_front();
                if (o_out_vertex_a !== ex.va) begin
                    $error("out_vertex_a exp %0d got %0d", ex.va, o_out_vertex_a); err_cnt++;
                end
                if (o_out_vertex_b !== ex.vb) begin
                    $error("out_vertex_b exp %0d got %0d", ex.vb, o_out_vertex_b); err_cnt++;
                end
                if (o_add_a_x !== ex.add_a[0]) begin
                    $error("add_a_x exp %0d got %0d", ex.add_a[0], o_add_a_x); err_cnt++;
                end
                if (o_add_a_y !== ex.add_a[1]) begin
                    $error("add_a_y exp %0d got %0d", ex.add_a[1], o_add_a_y); err_cnt++;
                end
                if (o_add_a_z !== ex.add_a[2]) begin
                    $error("add_a_z exp %0d got %0d", ex.add_a[2], o_add_a_z); err_cnt++;
                end
                if (o_add_b_x !== ex.add_b[0]) begin
                    $error("add_b_x exp %0d got %0d", ex.add_b[0], o_add_b_x); err_cnt++;
                end
                if (o_add_b_y !== ex.add_b[1]) begin
                    $error("add_b_y exp %0d got %0d", ex.add_b[1], o_add_b_y); err_cnt++;
                end
                if (o_add_b_z !== ex.add_b[2]) begin
                    $error("add_b_z exp %0d got %0d", ex.add_b[2], o_add_b_z); err_cnt++;
                end
                if (o_write_a !== ex.wr_a) begin
                    $error("write_a exp %0d got %0d", ex.wr_a, o_write_a); err_cnt++;
                end
                if (o_write_b !== ex.wr_b) begin
                    $error("write_b exp %0d got %0d", ex.wr_b, o_write_b); err_cnt++;
                end
            end
        end
    end

    // Field extremes, zero length, short edge, free edges
    task automatic test_directed_edges();
        begin
            send_item(make_edge(0, 4095, 0, 0, 0, 0, 0, 0, 0, 0));
            send_item(make_edge(4095, 0, 32'sh7FFF_FFFF, -32'sh8000_0000, 0,
                                -32'sh8000_0000, 32'sh7FFF_FFFF, 0,
                                31'h7FFF_FFFF, 31'h7FFF_FFFF));
            send_item(make_edge(1, 2, -32'sh8000_0000, -32'sh8000_0000, -32'sh8000_0000,
                                32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                                31'h7FFF_FFFF, 31'h0001_0000));
            send_item(make_edge(3, 4, 1, 0, 0, 0, 0, 0, 31'h0001_0000, 31'h0001_0000));
            send_item(make_edge(3, 4, 2, 0, 0, 0, 0, 0, 31'h0001_0000, 31'h0001_0000));
            send_item(make_edge(5, 6, 3 << 16, 4 << 16, 0, 0, 0, 0,
                                31'h0002_0000, 31'h0001_8000));
            send_item(make_edge(7, 8, -5, 7, -3, 9, -11, 13, 31'h7FFF_FFFF, 31'h7FFF_FFFF));
        end
    endtask

    // Pinned ends: one side, other side, both, and reload to free
    task automatic test_pinned_ends();
        begin
            send_item(make_load(10, 1'b1, 32'sh7FFF_FFFF, -32'sh8000_0000, 32'sh0001_0000));
            send_item(make_load(11, 1'b1, -32'sh0003_0000, 32'sh0002_0000, 0));
            send_item(make_edge(10, 12, 0, 0, 0, 1 << 16, 2 << 16, 3 << 16,
                                31'h0001_0000, 31'h7FFF_FFFF));
            send_item(make_edge(12, 11, 1 << 20, 0, -(1 << 20), 0, 0, 0,
                                31'h0004_0000, 31'h0002_0000));
            send_item(make_edge(10, 11, 1 << 16, 0, 0, 0, 0, 0, 31'h0001_0000, 31'h0001_0000));
            send_item(make_edge(11, 11, 0, 0, 0, 0, 0, 0, 31'h0001_0000, 31'h0001_0000));
            send_item(make_edge(12, 10, 0, 0, 0, 0, 0, 0, 31'h0001_0000, 31'h7FFF_FFFF));
            send_item(make_load(4095, 1'b1, -1, -1, -1));
            send_item(make_edge(0, 4095, 5 << 16, 0, 0, 0, 0, 0, 31'h0001_0000, 31'h0001_0000));
            send_item(make_load(10, 1'b0, 0, 0, 0));
            send_item(make_load(4095, 1'b0, 0, 0, 0));
            send_item(make_edge(10, 4095, 1 << 16, 1 << 16, 0, 0, 0, 0,
                                31'h0001_0000, 31'h0001_0000));
        end
    endtask

    // Random stream, run after writing the given min_length setting
    task automatic test_random_stream(input int n_items, input logic [LEN_W-1:0] ml);
        begin
            write_min_length(ml);
            for (int n = 0; n < n_items; n++) begin
                if (n % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
                send_item(rand_item());
            end
            no_idle = 1'b0;
        end
    endtask

    initial begin
        i_rst_n = 1'b0; i_cfg_wr_en = 1'b0; i_cfg_wr_data = '0;
        i_valid = 1'b0; i_stall = 1'b0; i_command = CMD_EDGE; i_pin_flag = 1'b0;
        i_vertex_a = '0; i_vertex_b = '0;
        i_pos_a_x = '0; i_pos_a_y = '0; i_pos_a_z = '0;
        i_pos_b_x = '0; i_pos_b_y = '0; i_pos_b_z = '0;
        i_rest_length = '0; i_stiffness = '0;
        err_cnt = 0; no_idle = 1'b0; stall_left = 0;
        min_len = 31'd1;
        for (int v = 0; v < NVERT; v++) pin_flags[v] = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_edges();
        test_pinned_ends();
        test_random_stream(400, 31'd0);
        test_random_stream(300, 31'h7FFF_FFFF);
        test_random_stream(350, 31'h0001_0000);
        test_random_stream(300, 31'd1);

        // Wait for the last results, then settle
        i_valid = 1'b0;
        while (pending_rhs.size() != 0) @(negedge i_clk);
        repeat (PIPE_LAT + 8) @(negedge i_clk);
        if (err_cnt == 0 && pending_rhs.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
